>>> rtl/core/sfmf_pkg.sv
// Shared types and constants for the substring first-match finder.
`default_nettype none

package sfmf_pkg;

    // Fixed field widths
    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 5;
    localparam int INDEX_W   = 16;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 2;
    localparam int PAT_BYTES = 16;
    localparam int PAT_W     = PAT_BYTES * BYTE_W;

    // Parameter defaults
    localparam int PATTERN_MAX_DEF = 16;
    localparam int TEXT_MAX_DEF    = 65536;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_LENGTH = 2'd0,
        REG_PATTERN_LOW    = 2'd1,
        REG_PATTERN_HIGH   = 2'd2
    } cfg_reg_t;

    // Control handed to every window cell
    typedef struct packed {
        logic             shift;
        logic             clear;
        logic [LEN_W-1:0] len;
    } cell_ctl_t;

    // One result beat
    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] match_index;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/core/substring_first_match_finder.sv
// Top level of the substring first-match finder.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one text byte per beat with
//   last_of_text marking the final byte of a text. Output channel
//   (out_valid/out_ready) carries found and match_index.
//   Each text yields exactly one result beat: found = 1 with the start index
//   of the first match (at the byte that completes it), or found = 0 with
//   index 0 on the final byte when nothing matched.
//   Configuration (cfg_write/cfg_index/cfg_data) sets the pattern length and
//   pattern bytes; write it only while no text is in flight.
// Timing:
//   One byte per cycle sustained while in_ready is high; the window compare
//   across the cell row is done in the accepting cycle. When the output slot
//   is free, the result beat is registered into it at the accepting edge, so
//   out_valid rises right after it and the beat can leave at the next edge.
//   When the receiver stalls, an output register plus one skid entry hold
//   results; in_ready drops only while both are occupied.
// Reset:
//   Clears the window, position, found flag and output beats; pattern
//   length resets to 1, pattern bytes to zero.
`default_nettype none

module substring_first_match_finder
    import sfmf_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF,
    parameter int TEXT_MAX    = TEXT_MAX_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [BYTE_W-1:0]    text_byte,
    input  wire logic                 last_of_text,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic                      found,
    output logic [INDEX_W-1:0]        match_index
);

    localparam int POS_SAT = TEXT_MAX + PATTERN_MAX;
    localparam int POS_W   = $clog2(POS_SAT + 1);
    localparam int CALC_W  = POS_W + 1;

    // Configuration registers
    logic [LEN_W-1:0] len_reg;
    logic [CFG_W-1:0] pat_low_reg;
    logic [CFG_W-1:0] pat_high_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg      <= LEN_W'(1);
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_PATTERN_LENGTH: len_reg      <= cfg_data[LEN_W-1:0];
                REG_PATTERN_LOW:    pat_low_reg  <= cfg_data;
                REG_PATTERN_HIGH:   pat_high_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    // Clamp pattern length to 1..PATTERN_MAX
    logic [LEN_W-1:0] len_used;

    always_comb
    begin
        if (len_reg == '0)
        begin
            len_used = LEN_W'(1);
        end
        else if (len_reg > LEN_W'(PATTERN_MAX))
        begin
            len_used = LEN_W'(PATTERN_MAX);
        end
        else
        begin
            len_used = len_reg;
        end
    end

    // Cell row
    logic                accept;
    cell_ctl_t           ctl;
    logic [PAT_W-1:0]    pattern;
    logic [BYTE_W-1:0]   chain [PATTERN_MAX+1];
    logic [PATTERN_MAX-1:0] hits;

    assign accept    = in_valid && in_ready;
    assign ctl.shift = accept;
    assign ctl.clear = accept && last_of_text;
    assign ctl.len   = len_used;
    assign pattern   = {pat_high_reg, pat_low_reg};
    assign chain[0]  = text_byte;

    for (genvar j = 0; j < PATTERN_MAX; j++)
    begin : g_cell
        sfmf_cell #(
            .IDX(j)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (ctl),
            .pattern (pattern),
            .byte_in (chain[j]),
            .byte_out(chain[j+1]),
            .hit     (hits[j])
        );
    end

    // Position and found tracking
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    logic              found_reg;
    logic              found_next;
    logic [CALC_W-1:0] pos_plus;
    logic [CALC_W-1:0] start;
    logic              match_fire;
    logic              miss_fire;
    result_t           result;

    assign pos_plus   = CALC_W'(pos_reg) + CALC_W'(1);
    assign start      = pos_plus - CALC_W'(len_used);
    assign match_fire = !found_reg && (pos_plus >= CALC_W'(len_used))
                        && (start < CALC_W'(TEXT_MAX)) && (&hits);
    assign miss_fire  = !found_reg && !match_fire && last_of_text;

    always_comb
    begin
        pos_next   = pos_reg;
        found_next = found_reg;
        if (accept)
        begin
            if (last_of_text)
            begin
                pos_next   = '0;
                found_next = 1'b0;
            end
            else
            begin
                if (pos_reg < POS_W'(POS_SAT))
                begin
                    pos_next = pos_reg + POS_W'(1);
                end
                if (match_fire)
                begin
                    found_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            pos_reg   <= pos_next;
            found_reg <= found_next;
        end
    end

    // Build the result beat
    assign result.found       = match_fire;
    assign result.match_index = match_fire ? INDEX_W'(start) : '0;

    result_t out_data;

    sfmf_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept && (match_fire || miss_fire)),
        .push_data (result),
        .push_ready(in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign found       = out_data.found;
    assign match_index = out_data.match_index;

endmodule

`default_nettype wire

>>> rtl/core/sfmf_cell.sv
// One window cell: holds one text byte, passes it on, and compares against its pattern byte.
`default_nettype none

module sfmf_cell
    import sfmf_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cell_ctl_t         ctl,
    input  wire logic [PAT_W-1:0]  pattern,
    input  wire logic [BYTE_W-1:0] byte_in,
    output logic      [BYTE_W-1:0] byte_out,
    output logic                   hit
);

    localparam logic [LEN_W-1:0] MY_POS = LEN_W'(IDX);

    logic [BYTE_W-1:0]       byte_reg;
    logic [BYTE_W-1:0]       byte_next;
    logic [$clog2(PAT_BYTES)-1:0] sel;
    logic [BYTE_W-1:0]       expect_byte;

    // Pick the pattern byte that lines up with this window slot
    assign sel         = ($clog2(PAT_BYTES))'(ctl.len - LEN_W'(1) - MY_POS);
    assign expect_byte = pattern[sel*BYTE_W +: BYTE_W];

    // Slots beyond the pattern length always agree
    assign hit = (MY_POS >= ctl.len) || (byte_in == expect_byte);

    // Advance on each accepted beat, drop contents at end of text
    always_comb
    begin
        byte_next = byte_reg;
        if (ctl.clear)
        begin
            byte_next = '0;
        end
        else if (ctl.shift)
        begin
            byte_next = byte_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= '0;
        end
        else
        begin
            byte_reg <= byte_next;
        end
    end

    assign byte_out = byte_reg;

endmodule

`default_nettype wire

>>> rtl/core/sfmf_out_buf.sv
// Output register with a skid stage for result beats.
`default_nettype none

module sfmf_out_buf
    import sfmf_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire result_t push_data,
    output logic         push_ready,
    output logic         out_valid,
    input  wire logic    out_ready,
    output result_t      out_data
);

    result_t out_reg;
    result_t out_next;
    result_t skid_reg;
    result_t skid_next;
    logic    out_valid_reg;
    logic    out_valid_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;
    logic    out_free;

    // Output slot can take a beat this cycle
    assign out_free = !out_valid_reg || out_ready;

    // Move skid into output first; park a new beat in skid when output stalls
    always_comb
    begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg)
        begin
            if (out_free)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (out_free)
            begin
                out_next       = push_data;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = push_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign push_ready = !skid_valid_reg;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_reg;

endmodule

`default_nettype wire

>>> rtl/core/sfmf_chk.sv
// Port-level checker for the substring first-match finder, bound to the top level.
`default_nettype none

module sfmf_chk
    import sfmf_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_ready,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic               found,
    input wire logic [INDEX_W-1:0] match_index
);

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(found) && $stable(match_index))
        else $error("result beat changed while stalled");

    // Not-found beats carry index zero
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> match_index == '0)
        else $error("not-found beat with nonzero index");

    // Input backpressure only when the output slot is occupied
    a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("in_ready low with empty output");

    // A full buffer drains its skid entry into the output slot
    a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !in_ready |=> out_valid && in_ready)
        else $error("skid entry not moved to output");

endmodule

bind substring_first_match_finder sfmf_chk u_sfmf_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .found      (found),
    .match_index(match_index)
);

`default_nettype wire

>>> test/testbench.sv
// Testbench for the substring first-match finder: directed rows and random texts.
`timescale 1ns / 1ps

module testbench
    import sfmf_pkg::*;
();

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int RANDOM_BYTES = 1200;
    localparam int POS_CEILING = TEXT_MAX_DEF + PATTERN_MAX_DEF;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_MODEL,
        ROW_NONE,
        ROW_RESULT
    } row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [4:0]  len;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [7:0]  b;
        logic        last;
        result_t     want;
    } plan_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_PATTERN_LENGTH;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [BYTE_W-1:0]    text_byte = '0;
    logic                 last_of_text = 1'b0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic                 found;
    logic [INDEX_W-1:0]   match_index;

    // Search state mirrored from the block
    logic [4:0]  pat_len_reg = 5'd1;
    logic [63:0] pat_lo_reg = '0;
    logic [63:0] pat_hi_reg = '0;
    logic [7:0]  recent [16];
    int unsigned text_pos = 0;
    bit          match_seen = 1'b0;

    result_t     awaited_reports[$];
    plan_row_t   plan[$];
    bit          tx_calm = 1'b0;
    int          mismatches = 0;
    int          cycle_count = 0;

    substring_first_match_finder uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .text_byte    (text_byte),
        .last_of_text (last_of_text),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .found        (found),
        .match_index  (match_index)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned used_len();
        if (pat_len_reg == 5'd0)
            return 1;
        if (pat_len_reg > PATTERN_MAX_DEF)
            return PATTERN_MAX_DEF;
        return pat_len_reg;
    endfunction

    function automatic logic [7:0] pat_byte(input int unsigned k);
        logic [127:0] all_bytes;
        all_bytes = {pat_hi_reg, pat_lo_reg};
        return all_bytes[8*k +: 8];
    endfunction

    // Shift one byte into the window and work out the report it causes
    function automatic void track_byte(input logic [7:0] b, input logic l,
                                       output bit got, output result_t res);
        int unsigned n;
        int unsigned start;
        int unsigned k;
        bit          hit;
        n = used_len();
        got = 1'b0;
        res = '0;
        for (k = 15; k > 0; k--)
            recent[k] = recent[k-1];
        recent[0] = b;
        if (!match_seen && text_pos + 1 >= n)
        begin
            start = text_pos + 1 - n;
            hit = (start < TEXT_MAX_DEF);
            for (k = 0; k < n; k++)
                if (recent[n-1-k] != pat_byte(k))
                    hit = 1'b0;
            if (hit)
            begin
                match_seen = 1'b1;
                got = 1'b1;
                res.found = 1'b1;
                res.match_index = 16'(start);
            end
        end
        if (text_pos < POS_CEILING)
            text_pos++;
        // Close the text: report a miss if nothing matched, then clear
        if (l)
        begin
            if (!match_seen)
            begin
                got = 1'b1;
                res = '0;
            end
            for (k = 0; k < 16; k++)
                recent[k] = 8'h00;
            text_pos = 0;
            match_seen = 1'b0;
        end
    endfunction

    function automatic void add_cfg(input logic [4:0] len, input logic [63:0] lo,
                                    input logic [63:0] hi);
        plan_row_t r;
        r = '0;
        r.kind = ROW_CFG;
        r.len = len;
        r.lo = lo;
        r.hi = hi;
        plan.push_back(r);
    endfunction

    function automatic void add_text(input logic [7:0] b, input logic l,
                                     input row_kind_t kind, input logic f,
                                     input logic [15:0] idx);
        plan_row_t r;
        r = '0;
        r.kind = kind;
        r.b = b;
        r.last = l;
        r.want.found = f;
        r.want.match_index = idx;
        plan.push_back(r);
    endfunction

    // Drop valid, wait for the last report, then let the block settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (awaited_reports.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write all three pattern registers; junk above the length field is ignored
    task automatic load_pattern(input logic [4:0] len, input logic [63:0] lo,
                                input logic [63:0] hi);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        cfg_write <= 1'b1;
        cfg_index <= REG_PATTERN_LENGTH;
        cfg_data <= {junk[63:5], len};
        @(posedge clk);
        cfg_index <= REG_PATTERN_LOW;
        cfg_data <= lo;
        @(posedge clk);
        cfg_index <= REG_PATTERN_HIGH;
        cfg_data <= hi;
        @(posedge clk);
        cfg_write <= 1'b0;
        pat_len_reg = len;
        pat_lo_reg = lo;
        pat_hi_reg = hi;
    endtask

    // Send one text byte and queue what it should report
    task automatic feed(input logic [7:0] b, input logic l, input row_kind_t kind,
                        input result_t want);
        int      gap;
        bit      got;
        result_t res;
        gap = tx_calm ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        text_byte <= b;
        last_of_text <= l;
        @(posedge clk);
        while (in_ready !== 1'b1)
            @(posedge clk);
        track_byte(b, l, got, res);
        if (kind == ROW_MODEL && got)
            awaited_reports.push_back(res);
        else if (kind == ROW_RESULT)
            awaited_reports.push_back(want);
    endtask

    // Check every result beat against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_ready)
        begin
            if (awaited_reports.size() == 0)
            begin
                $error("unexpected result beat: found=%0d match_index=%0d",
                       found, match_index);
                mismatches++;
            end
            else
            begin
                if (found !== awaited_reports[0].found)
                begin
                    $error("found: expected %0d, got %0d",
                           awaited_reports[0].found, found);
                    mismatches++;
                end
                if (match_index !== awaited_reports[0].match_index)
                begin
                    $error("match_index: expected %0d, got %0d",
                           awaited_reports[0].match_index, match_index);
                    mismatches++;
                end
                void'(awaited_reports.pop_front());
            end
        end
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Stall the result side in runs, some of them without any stall
    initial
    begin : result_side
        int gap;
        int run;
        bit calm;
        run = 0;
        calm = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (run == 0)
            begin
                run = $urandom_range(1, 12);
                calm = ($urandom_range(0, 3) == 0);
            end
            run--;
            gap = calm ? 0 : $urandom_range(0, 17);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (out_valid !== 1'b1)
                @(posedge clk);
        end
    end

    initial
    begin : stimulus
        int          k;
        int          n;
        int          tlen;
        int          mode;
        int          at;
        int          sent;
        int          cfg_loads;
        logic [4:0]  len;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [7:0]  txt[$];
        for (k = 0; k < 16; k++)
            recent[k] = 8'h00;

        // Directed rows; pattern after reset is one zero byte
        add_text(8'h00, 1'b0, ROW_RESULT, 1'b1, 16'd0);
        add_text(8'hFF, 1'b1, ROW_NONE, 1'b0, 16'd0);
        add_text(8'hFF, 1'b1, ROW_RESULT, 1'b0, 16'd0);
        // Length zero acts as one; match on the final byte
        add_cfg(5'd0, 64'h0000_0000_0000_00FF, 64'h0);
        add_text(8'h00, 1'b0, ROW_NONE, 1'b0, 16'd0);
        add_text(8'hFF, 1'b1, ROW_RESULT, 1'b1, 16'd1);
        // Three-byte pattern with a false start
        add_cfg(5'd3, 64'hFFFF_FFFF_FF43_4241, 64'hFFFF_FFFF_FFFF_FFFF);
        add_text(8'h41, 1'b0, ROW_MODEL, 1'b0, 16'd0);
        add_text(8'h42, 1'b0, ROW_MODEL, 1'b0, 16'd0);
        add_text(8'h41, 1'b0, ROW_MODEL, 1'b0, 16'd0);
        add_text(8'h42, 1'b0, ROW_MODEL, 1'b0, 16'd0);
        add_text(8'h43, 1'b0, ROW_MODEL, 1'b0, 16'd0);
        add_text(8'h41, 1'b0, ROW_MODEL, 1'b0, 16'd0);
        add_text(8'h42, 1'b0, ROW_MODEL, 1'b0, 16'd0);
        add_text(8'h43, 1'b1, ROW_MODEL, 1'b0, 16'd0);
        // Text shorter than the pattern
        add_text(8'h41, 1'b0, ROW_NONE, 1'b0, 16'd0);
        add_text(8'h42, 1'b1, ROW_RESULT, 1'b0, 16'd0);
        // Oversized length clamps to sixteen zero bytes; cleared window must not match
        add_cfg(5'd31, 64'h0, 64'h0);
        add_text(8'h00, 1'b0, ROW_NONE, 1'b0, 16'd0);
        add_text(8'h00, 1'b0, ROW_NONE, 1'b0, 16'd0);
        add_text(8'h00, 1'b1, ROW_RESULT, 1'b0, 16'd0);
        // Zero bytes are ordinary pattern bytes
        add_cfg(5'd2, 64'h0, 64'h0);
        add_text(8'h00, 1'b0, ROW_NONE, 1'b0, 16'd0);
        add_text(8'h00, 1'b1, ROW_RESULT, 1'b1, 16'd0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        for (k = 0; k < plan.size(); k++)
        begin
            if (plan[k].kind == ROW_CFG)
            begin
                wait_idle();
                load_pattern(plan[k].len, plan[k].lo, plan[k].hi);
            end
            else
                feed(plan[k].b, plan[k].last, plan[k].kind, plan[k].want);
        end

        // Random texts, mostly built around the pattern
        sent = 0;
        cfg_loads = 0;
        while (sent < RANDOM_BYTES)
        begin
            if (cfg_loads < 4 || $urandom_range(0, 3) == 0)
            begin
                case (cfg_loads)
                    0: len = 5'd16;
                    1: len = 5'd0;
                    2: len = 5'd31;
                    3: len = 5'd1;
                    default: len = ($urandom_range(0, 1) == 0) ?
                                   5'($urandom_range(1, 4)) : 5'($urandom_range(0, 31));
                endcase
                case (cfg_loads)
                    0: begin lo = '1; hi = '1; end
                    1: begin lo = '0; hi = '0; end
                    default:
                    begin
                        lo = {$urandom, $urandom};
                        hi = {$urandom, $urandom};
                    end
                endcase
                wait_idle();
                load_pattern(len, lo, hi);
                cfg_loads++;
            end
            tx_calm = ($urandom_range(0, 4) == 0);
            n = used_len();
            tlen = $urandom_range(1, 3 * n + 8);
            mode = $urandom_range(0, 9);
            txt.delete();
            for (k = 0; k < tlen; k++)
                txt.push_back(mode < 7 ? pat_byte($urandom_range(0, n - 1)) :
                              8'($urandom));
            // Plant the pattern, sometimes with one flipped bit
            if (mode < 6 && tlen >= n)
            begin
                at = $urandom_range(0, tlen - n);
                for (k = 0; k < n; k++)
                    txt[at + k] = pat_byte(k);
                if (mode == 5)
                    txt[at + $urandom_range(0, n - 1)] ^= 8'(1 << $urandom_range(0, 7));
            end
            for (k = 0; k < tlen; k++)
            begin
                feed(txt[k], k == tlen - 1, ROW_MODEL, '0);
                sent++;
            end
        end

        // Drain and finish
        in_valid <= 1'b0;
        while (awaited_reports.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
